@@ rtl/cbd_pkg.sv @@
// ----------------------------------------------------------------------------
// cbd_pkg
// Types, character constants and the hex digit decoder shared by the
// chunked body decoder modules.
// ----------------------------------------------------------------------------
package cbd_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_of_request;
	} req_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       end_of_body;
	} body_t;

	// one possible result of a parser step
	typedef struct packed {
		logic  valid;
		body_t data;
	} res_t;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SIZE,
		PH_SKIP_PRE,
		PH_DATA,
		PH_SKIP_POST,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] digit;
	} hex_t;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UF = 8'h46;

	// offsets that map a letter onto its digit value (a -> 10)
	localparam logic [7:0] LC_BIAS = 8'h57;
	localparam logic [7:0] UC_BIAS = 8'h37;

	// index of the last byte of the CR LF CR LF header terminator
	localparam logic [1:0] HDR_LAST = 2'd3;

	// bytes skipped after a chunk's payload (CR LF)
	localparam logic [1:0] POST_SKIP = 2'd2;

	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t       h;
		logic [7:0] v;
		h = '0;
		v = '0;
		case (b) inside
			[CH_0:CH_9]: begin
				v = b - CH_0;
				h.ok = 1'b1;
			end
			[CH_LA:CH_LF_HEX]: begin
				v = b - LC_BIAS;
				h.ok = 1'b1;
			end
			[CH_UA:CH_UF]: begin
				v = b - UC_BIAS;
				h.ok = 1'b1;
			end
			default: begin
				v = '0;
				h.ok = 1'b0;
			end
		endcase
		h.digit = v[3:0];
		return h;
	endfunction

endpackage

@@ rtl/cbd_parser.sv @@
// ----------------------------------------------------------------------------
// cbd_parser
// Parse state of the request stream: header terminator match, chunk size
// accumulation, skips and payload counting. State moves once per step.
// ----------------------------------------------------------------------------
module cbd_parser import cbd_pkg::*; #(
	parameter int SIZE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  req_t item,
	output res_t res
);

	phase_t               phase_q, phase_d, cur_phase;
	logic [1:0]           match_q, match_d, cur_match;
	logic [SIZE_BITS-1:0] acc_q, acc_d, cur_acc;
	logic [SIZE_BITS-1:0] rem_q, rem_d, cur_rem;
	logic [1:0]           skip_q, skip_d, cur_skip;
	hex_t                 hex;
	logic [7:0]           want;

	// a request start acts on this byte as if from reset
	always_comb begin
		cur_phase = item.first_of_request ? PH_HEADER : phase_q;
		cur_match = item.first_of_request ? 2'd0 : match_q;
		cur_acc   = item.first_of_request ? '0 : acc_q;
		cur_rem   = item.first_of_request ? '0 : rem_q;
		cur_skip  = item.first_of_request ? 2'd0 : skip_q;
		hex       = hex_decode(item.data_byte);
		want      = cur_match[0] ? CH_LF : CH_CR;
	end

	// next state
	always_comb begin
		phase_d = cur_phase;
		match_d = cur_match;
		acc_d   = cur_acc;
		rem_d   = cur_rem;
		skip_d  = cur_skip;
		case (cur_phase)
			PH_HEADER: begin
				if (item.data_byte == want) begin
					if (cur_match == HDR_LAST) begin
						phase_d = PH_SIZE;
						match_d = 2'd0;
						acc_d   = '0;
					end else begin
						match_d = cur_match + 2'd1;
					end
				end else begin
					match_d = (item.data_byte == CH_CR) ? 2'd1 : 2'd0;
				end
			end
			PH_SIZE: begin
				if (hex.ok) begin
					// saturate once another digit would overflow
					if (cur_acc[SIZE_BITS-1 -: 4] != 4'd0)
						acc_d = '1;
					else
						acc_d = {cur_acc[SIZE_BITS-5:0], hex.digit};
				end else if (cur_acc == '0) begin
					phase_d = PH_DONE;
				end else begin
					rem_d   = cur_acc;
					skip_d  = 2'd1;
					phase_d = PH_SKIP_PRE;
				end
			end
			PH_SKIP_PRE: begin
				if (cur_skip > 2'd1) begin
					skip_d = cur_skip - 2'd1;
				end else begin
					skip_d  = 2'd0;
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				if (cur_rem > SIZE_BITS'(1)) begin
					rem_d = cur_rem - SIZE_BITS'(1);
				end else begin
					rem_d   = '0;
					skip_d  = POST_SKIP;
					phase_d = PH_SKIP_POST;
				end
			end
			PH_SKIP_POST: begin
				if (cur_skip > 2'd1) begin
					skip_d = cur_skip - 2'd1;
				end else begin
					skip_d  = 2'd0;
					acc_d   = '0;
					phase_d = PH_SIZE;
				end
			end
			default: begin
				phase_d = cur_phase;
			end
		endcase
	end

	// result of this step
	always_comb begin
		res = '0;
		case (cur_phase)
			PH_SIZE: begin
				if (!hex.ok && cur_acc == '0) begin
					res.valid            = 1'b1;
					res.data.end_of_body = 1'b1;
				end
			end
			PH_DATA: begin
				res.valid             = 1'b1;
				res.data.payload_byte = item.data_byte;
			end
			default: begin
				res.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			match_q <= 2'd0;
			acc_q   <= '0;
			rem_q   <= '0;
			skip_q  <= 2'd0;
		end else if (step) begin
			phase_q <= phase_d;
			match_q <= match_d;
			acc_q   <= acc_d;
			rem_q   <= rem_d;
			skip_q  <= skip_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_end_enters_done: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.valid && res.data.end_of_body |=> phase_q == PH_DONE)
		else $error("end of body did not enter done phase");

	a_data_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> rem_q != '0)
		else $error("data phase with no bytes remaining");

	a_done_size_zero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |-> acc_q == '0)
		else $error("done phase with nonzero size");
`endif

endmodule

@@ rtl/cbd_out_reg.sv @@
// ----------------------------------------------------------------------------
// cbd_out_reg
// Result register: holds one decoded beat until the sink takes it and
// reports when a new step may load it.
// ----------------------------------------------------------------------------
module cbd_out_reg import cbd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  res_t  res,
	output logic  free,
	output logic  valid,
	input  logic  ready,
	output body_t data
);

	logic  valid_q;
	body_t data_q;

	assign free  = !valid_q || ready;
	assign valid = valid_q;
	assign data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res.valid;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.valid)
			data_q <= res.data;
	end

`ifndef NO_ASSERTIONS
	a_end_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && data_q.end_of_body |-> data_q.payload_byte == 8'd0)
		else $error("end of body beat carries a payload byte");
`endif

endmodule

@@ rtl/http_chunked_body_decoder.sv @@
// A request stream enters one byte per beat; body beats leave carrying the
// decoded payload, and a final beat with end_of_body set marks the zero-size
// chunk. One byte is accepted every cycle while the sink keeps up; a byte
// enters the input register when it is accepted, and the parse step loads
// its beat into the result register once that register is free.
// Throughput is set by the single parse step per cycle, whose longest path is
// the SIZE_BITS-wide chunk counter decrement and compare.
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Top level: input register, chunked transfer parser and result register.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder import cbd_pkg::*; #(
	parameter int SIZE_BITS = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_ready,
	input  req_t  req,
	output logic  body_valid,
	input  logic  body_ready,
	output body_t body
);

	logic valid_s1;
	req_t data_s1;
	logic step;
	logic free;
	res_t res;

	// advance the held byte whenever the result register can take its outcome
	assign step      = valid_s1 && free;
	assign req_ready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready)
			data_s1 <= req;
	end

	cbd_parser #(
		.SIZE_BITS(SIZE_BITS)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.item  (data_s1),
		.res   (res)
	);

	cbd_out_reg u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (step),
		.res   (res),
		.free  (free),
		.valid (body_valid),
		.ready (body_ready),
		.data  (body)
	);

`ifndef NO_ASSERTIONS
	a_stall_holds_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> valid_s1 && body_valid)
		else $error("input stalled with nothing held");
`endif

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the chunked body decoder. Request bytes go in
// through a stalling source and body beats come out into a stalling sink. A
// scoreboard predicts every beat from the accepted bytes and compares the
// beats field by field, in order. The stimulus is a short hand-built pair of
// requests, then random requests: mostly well-formed ones, plus oversized
// chunk sizes, prefixed or empty sizes, and line noise.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cbd_pkg::*;

	localparam int SIZE_BITS   = 32;
	localparam int RANDOM_BYTES = 1150;
	localparam logic [SIZE_BITS-1:0] SIZE_SAT = '1;

	// Predicts body beats from request bytes and checks what the block emits.
	class body_scoreboard;
		phase_t               phase;
		logic [1:0]           hdr_hits;
		logic [SIZE_BITS-1:0] size_acc;
		logic [SIZE_BITS-1:0] remaining;
		logic [1:0]           skip_left;
		body_t                expected_q[$];
		int                   errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			phase     = PH_HEADER;
			hdr_hits  = '0;
			size_acc  = '0;
			remaining = '0;
			skip_left = '0;
		endfunction

		task log_mismatch(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		function void note_byte(req_t item);
			logic [7:0] b;
			logic [3:0] nib;
			logic       is_hex;
			body_t      beat;
			b = item.data_byte;
			nib = '0;
			is_hex = 1'b1;
			if (item.first_of_request)
				clear();
			case (phase)
				PH_HEADER: begin
					if (b == (hdr_hits[0] ? CH_LF : CH_CR)) begin
						if (hdr_hits == HDR_LAST) begin
							phase = PH_SIZE;
							hdr_hits = '0;
							size_acc = '0;
						end else begin
							hdr_hits++;
						end
					end else begin
						hdr_hits = (b == CH_CR) ? 2'd1 : 2'd0;
					end
				end
				PH_SIZE: begin
					if (b >= "0" && b <= "9")
						nib = 4'(b - "0");
					else if (b >= "a" && b <= "f")
						nib = 4'(b - "a" + 8'd10);
					else if (b >= "A" && b <= "F")
						nib = 4'(b - "A" + 8'd10);
					else
						is_hex = 1'b0;
					if (is_hex) begin
						// saturate once another digit would shift bits out
						if (size_acc > (SIZE_SAT >> 4))
							size_acc = SIZE_SAT;
						else
							size_acc = {size_acc[SIZE_BITS-5:0], nib};
					end else if (size_acc == '0) begin
						phase = PH_DONE;
						beat.payload_byte = '0;
						beat.end_of_body = 1'b1;
						expected_q = {expected_q, beat};
					end else begin
						remaining = size_acc;
						skip_left = 2'd1;
						phase = PH_SKIP_PRE;
					end
				end
				PH_SKIP_PRE: begin
					if (skip_left > 2'd1) begin
						skip_left--;
					end else begin
						skip_left = '0;
						phase = PH_DATA;
					end
				end
				PH_DATA: begin
					beat.payload_byte = b;
					beat.end_of_body = 1'b0;
					expected_q = {expected_q, beat};
					if (remaining > 1) begin
						remaining--;
					end else begin
						remaining = '0;
						skip_left = POST_SKIP;
						phase = PH_SKIP_POST;
					end
				end
				PH_SKIP_POST: begin
					if (skip_left > 2'd1) begin
						skip_left--;
					end else begin
						skip_left = '0;
						size_acc = '0;
						phase = PH_SIZE;
					end
				end
				default: begin
				end
			endcase
		endfunction

		task check_beat(body_t got);
			body_t want;
			if (expected_q.size() == 0) begin
				log_mismatch($sformatf("unexpected beat payload %h end %b",
					got.payload_byte, got.end_of_body));
				return;
			end
			want = expected_q.pop_front();
			if (got.payload_byte !== want.payload_byte)
				log_mismatch($sformatf("payload_byte %h, want %h",
					got.payload_byte, want.payload_byte));
			if (got.end_of_body !== want.end_of_body)
				log_mismatch($sformatf("end_of_body %b, want %b",
					got.end_of_body, want.end_of_body));
		endtask
	endclass

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_ready;
	req_t  req;
	logic  body_valid;
	logic  body_ready;
	body_t body;

	body_scoreboard sb;
	int   sent;
	logic new_req;
	logic calm;

	http_chunked_body_decoder #(.SIZE_BITS(SIZE_BITS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.body_valid(body_valid),
		.body_ready(body_ready),
		.body      (body)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		body_ready <= calm || ($urandom_range(99) >= 37);
	end

	always @(posedge clk) begin
		if (arst_n && body_valid && body_ready)
			sb.check_beat(body);
	end

	initial begin
		#2_000_000;
		$display("FAIL http_chunked_body_decoder");
		$finish;
	end

	// One request byte; first_of_request comes from new_req, which drops after use.
	task automatic send_byte(input logic [7:0] b);
		req_t item;
		item.data_byte = b;
		item.first_of_request = new_req;
		new_req = 1'b0;
		calm = (sent >= 400 && sent < 700);
		while (!calm && $urandom_range(99) < 37) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		sb.note_byte(item);
		sent++;
	endtask

	function automatic logic [7:0] non_hex_byte();
		case ($urandom_range(5))
			0: return ";";
			1: return " ";
			2: return 8'h09;
			3: return "x";
			4: return "+";
			default: return CH_CR;
		endcase
	endfunction

	// Hex text of val, digits long, each letter in a random case.
	task automatic send_hex(input logic [47:0] val, input int digits);
		logic [3:0] nib;
		for (int i = digits - 1; i >= 0; i--) begin
			nib = val[4*i +: 4];
			if (nib < 4'd10)
				send_byte("0" + 8'(nib));
			else
				send_byte(($urandom_range(1) ? "A" : "a") + 8'(nib) - 8'd10);
		end
	endtask

	task automatic send_header();
		int n;
		n = $urandom_range(6);
		repeat (n) send_byte(8'($urandom));
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte(CH_CR);
		send_byte(CH_LF);
	endtask

	task automatic send_request(input int kind);
		int         n;
		int         len;
		int         digits;
		logic [47:0] val;
		case (kind)
			0: begin
				send_header();
				n = $urandom_range(4);
				repeat (n) begin
					len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
					send_hex(48'(len), (len < 16 ? 1 : 2) + $urandom_range(2));
					send_byte(($urandom_range(4) == 0) ? non_hex_byte() : CH_CR);
					send_byte(($urandom_range(7) == 0) ? 8'($urandom) : CH_LF);
					repeat (len) send_byte(8'($urandom));
					send_byte(CH_CR);
					send_byte(CH_LF);
				end
				send_hex(48'd0, $urandom_range(1, 3));
				send_byte(($urandom_range(3) == 0) ? non_hex_byte() : CH_CR);
				n = $urandom_range(4);
				repeat (n) send_byte(8'($urandom));
			end
			1: begin
				// large chunk size of eight to twelve digits, saturating past eight; pass a few bytes, abandon
				send_header();
				digits = $urandom_range(8, 12);
				val = {16'($urandom), 32'($urandom)};
				val[4*(digits-1)] = 1'b1;
				send_hex(val, digits);
				send_byte(CH_CR);
				send_byte(CH_LF);
				n = $urandom_range(1, 6);
				repeat (n) send_byte(8'($urandom));
			end
			2: begin
				// size text that stops before any digit, or right after a zero
				send_header();
				if ($urandom_range(3) == 0)
					send_byte("0");
				send_byte(non_hex_byte());
				send_hex(48'h1A, 2);
				send_byte(CH_CR);
				send_byte(CH_LF);
				n = $urandom_range(3);
				repeat (n) send_byte(8'($urandom));
			end
			default: begin
				n = $urandom_range(1, 20);
				repeat (n) begin
					case ($urandom_range(9))
						0, 1, 2: val[7:0] = CH_CR;
						3, 4:    val[7:0] = CH_LF;
						5, 6:    val[7:0] = "0" + 8'($urandom_range(9));
						default: val[7:0] = 8'($urandom);
					endcase
					new_req = ($urandom_range(9) == 0);
					send_byte(val[7:0]);
				end
			end
		endcase
	endtask

	initial begin
		int guard;
		int pick;
		sb = new();
		sent = 0;
		new_req = 1'b0;
		calm = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		body_ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no request start after reset; junk, a repeated CR, then the terminator
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(CH_CR);
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte(CH_CR);
		send_byte(CH_LF);
		// two-byte chunk with extreme payload values
		send_byte("2");
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_CR);
		send_byte(CH_LF);
		// empty size ends the body; the next byte is dropped
		send_byte("x");
		send_byte("A");
		// new request with a 0x prefix: the zero ends the body
		new_req = 1'b1;
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte("0");
		send_byte("x");
		send_byte("1");

		while (sent < RANDOM_BYTES + 23) begin
			new_req = 1'b1;
			pick = $urandom_range(99);
			if (pick < 65)
				send_request(0);
			else if (pick < 75)
				send_request(1);
			else if (pick < 85)
				send_request(2);
			else
				send_request(3);
		end
		req_valid <= 1'b0;

		guard = 0;
		while (sb.expected_q.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (16) @(posedge clk);
		if (sb.expected_q.size() != 0)
			sb.log_mismatch($sformatf("%0d expected beats never arrived",
				sb.expected_q.size()));
		if (sb.errors == 0)
			$display("PASS http_chunked_body_decoder");
		else
			$display("FAIL http_chunked_body_decoder");
		$finish;
	end

endmodule

@@ files.f @@
rtl/cbd_pkg.sv
rtl/cbd_parser.sv
rtl/cbd_out_reg.sv
rtl/http_chunked_body_decoder.sv
verif/tb.sv
